// ----- sv/arcade_drive_mixer_quad_deadband_assert.svh -----
// assertion macros used by the arcade drive mixer top level
`ifndef ARCADE_DRIVE_MIXER_QUAD_DEADBAND_ASSERT_SVH
`define ARCADE_DRIVE_MIXER_QUAD_DEADBAND_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define ADM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define ADM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/adm_pkg.sv -----
// shared types and codes for the arcade drive mixer
package adm_pkg;

    // width of the configuration register index
    localparam int CFG_IDX_W = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEAD_THRESHOLD = 8'd0,
        CFG_MIN_OUTPUT     = 8'd1,
        CFG_AXIS_GAIN      = 8'd2
    } cfg_idx_t;

    // per-axis flags that travel along the deadband pipeline
    typedef struct packed {
        logic live;   // magnitude lies above the threshold
        logic neg;    // output sign, the axis sign flipped when invert is set
    } adm_side_t;

endpackage

// ----- sv/adm_if.sv -----
// stream and configuration interfaces for the arcade drive mixer

// joystick sample stream
interface joy_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] joy_x;
    logic signed [SAMPLE_BITS-1:0] joy_y;
    logic signed [SAMPLE_BITS-1:0] joy_z;

    modport source (output valid, output joy_x, output joy_y, output joy_z, input ready);
    modport sink   (input valid, input joy_x, input joy_y, input joy_z, output ready);
endinterface

// motor drive result stream
interface drive_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_cmd;
    logic signed [SAMPLE_BITS-1:0] right_cmd;

    modport source (output valid, output left_cmd, output right_cmd, input ready);
    modport sink   (input valid, input left_cmd, input right_cmd, output ready);
endinterface

// configuration write channel
interface cfg_if #(
    parameter int DATA_BITS = 15
);
    import adm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/arcade_drive_mixer_quad_deadband.sv -----
// top level of the arcade drive mixer with quadratic deadband
//
// Takes one joystick sample per cycle while the output is not held off and returns
// one left/right drive pair per sample. Each axis is scaled by axis_gain, shaped
// by a quadratic deadband and then mixed arcade style; the right side comes out
// negated. Most of the pipeline depth comes from the restoring divider of the
// deadband, which spends one pipeline stage per quotient bit. Every stage carries
// its own valid bit and empty stages fill while the output is stalled, so new
// samples keep flowing in until the whole pipeline is full. Configuration writes
// are always taken and should be made while the pipeline is empty; besides the
// three registers, the configuration state holds the precomputed divisor and span.
`include "arcade_drive_mixer_quad_deadband_assert.svh"

module arcade_drive_mixer_quad_deadband #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    joy_if.sink      joy,
    drive_if.source  drive,
    cfg_if.sink      cfg
);
    import adm_pkg::*;

    localparam int W       = SAMPLE_BITS;
    localparam int F       = SAMPLE_BITS - 1;
    localparam int LANE_NS = SAMPLE_BITS + 5;
    localparam int NS      = LANE_NS + 2;
    localparam logic [F:0]   ONE_Q    = {1'b1, {F{1'b0}}};
    localparam logic [F-1:0] THR_RST  = F'((longint'(2) << F) / 5);
    localparam logic [F-1:0] MIN_RST  = F'((longint'(3) << F) / 10);
    localparam logic [F-1:0] GAIN_RST = F'((longint'(3) << F) / 4);

    logic [F-1:0]        thr_reg;
    logic [F-1:0]        thr_next;
    logic [F-1:0]        minv_reg;
    logic [F-1:0]        minv_next;
    logic [F-1:0]        gain_reg;
    logic [F-1:0]        gain_next;
    logic [F:0]          den_reg;
    logic [F:0]          den_next;
    logic [F:0]          omm_reg;
    logic [F:0]          omm_next;
    logic [NS-1:0]       vld_reg;
    logic [NS-1:0]       en;
    logic signed [W-1:0] dbx;
    logic signed [W-1:0] dby;
    logic signed [W-1:0] dbz;

    // configuration registers, with divisor and span kept precomputed
    assign cfg.ready = 1'b1;

    always_comb
    begin
        thr_next  = thr_reg;
        minv_next = minv_reg;
        gain_next = gain_reg;
        den_next  = den_reg;
        omm_next  = omm_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_DEAD_THRESHOLD:
                begin
                    thr_next = cfg.data;
                    den_next = ONE_Q - {1'b0, cfg.data};
                end
                CFG_MIN_OUTPUT:
                begin
                    minv_next = cfg.data;
                    omm_next  = ONE_Q - {1'b0, cfg.data};
                end
                CFG_AXIS_GAIN:
                begin
                    gain_next = cfg.data;
                end
                default:
                begin
                    thr_next = thr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RST;
            minv_reg <= MIN_RST;
            gain_reg <= GAIN_RST;
            den_reg  <= ONE_Q - {1'b0, THR_RST};
            omm_reg  <= ONE_Q - {1'b0, MIN_RST};
        end
        else
        begin
            thr_reg  <= thr_next;
            minv_reg <= minv_next;
            gain_reg <= gain_next;
            den_reg  <= den_next;
            omm_reg  <= omm_next;
        end
    end

    // stage enables: a stage holds only when the output is stalled and it and every later stage are full
    for (genvar i = 0; i < NS; i++)
    begin : g_en
        assign en[i] = drive.ready | ~(&vld_reg[NS-1:i]);
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                    vld_reg[i] <= (i == 0) ? joy.valid : vld_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    assign joy.ready   = en[0];
    assign drive.valid = vld_reg[NS-1];

    // per-axis deadband lanes
    adm_lane #(
        .SAMPLE_BITS (W)
    ) u_lane_x (
        .clk    (clk),
        .en     (en[LANE_NS-1:0]),
        .raw    (joy.joy_x),
        .invert (1'b0),
        .gain   (gain_reg),
        .thr    (thr_reg),
        .minv   (minv_reg),
        .den    (den_reg),
        .omm    (omm_reg),
        .db_out (dbx)
    );

    adm_lane #(
        .SAMPLE_BITS (W)
    ) u_lane_y (
        .clk    (clk),
        .en     (en[LANE_NS-1:0]),
        .raw    (joy.joy_y),
        .invert (1'b1),
        .gain   (gain_reg),
        .thr    (thr_reg),
        .minv   (minv_reg),
        .den    (den_reg),
        .omm    (omm_reg),
        .db_out (dby)
    );

    adm_lane #(
        .SAMPLE_BITS (W)
    ) u_lane_z (
        .clk    (clk),
        .en     (en[LANE_NS-1:0]),
        .raw    (joy.joy_z),
        .invert (1'b0),
        .gain   (gain_reg),
        .thr    (thr_reg),
        .minv   (minv_reg),
        .den    (den_reg),
        .omm    (omm_reg),
        .db_out (dbz)
    );

    // mixing and output register
    adm_mix #(
        .SAMPLE_BITS (W)
    ) u_mix (
        .clk       (clk),
        .en        (en[NS-1:LANE_NS]),
        .x         (dbx),
        .y         (dby),
        .z         (dbz),
        .left_cmd  (drive.left_cmd),
        .right_cmd (drive.right_cmd)
    );

    // pipeline control checks
    `ADM_ASSERT_NOW(a_ready_follows_out, drive.ready, joy.ready, "input stalled while output is taken")
    `ADM_ASSERT_NOW(a_full_blocks_in, (&vld_reg) && !drive.ready, !joy.ready, "input taken into a full stalled pipeline")
    `ADM_ASSERT_NEXT(a_accept_enters, joy.valid && joy.ready, vld_reg[0], "accepted sample missing from first stage")
    `ADM_ASSERT_NEXT(a_count_kept, !joy.valid && !drive.ready, $countones(vld_reg) == $past($countones(vld_reg)), "sample lost or invented while stalled")
endmodule

// ----- sv/adm_div_step.sv -----
// one registered restoring-division step, producing one quotient bit
module adm_div_step #(
    parameter int FRAC_BITS = 15
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [FRAC_BITS:0]     den,
    input  logic [FRAC_BITS:0]     rem_in,
    input  logic [FRAC_BITS-1:0]   quo_in,
    input  adm_pkg::adm_side_t     side_in,
    output logic [FRAC_BITS:0]     rem_out,
    output logic [FRAC_BITS-1:0]   quo_out,
    output adm_pkg::adm_side_t     side_out
);
    import adm_pkg::*;

    localparam int F = FRAC_BITS;

    logic [F+1:0]   shifted;
    logic           take;
    logic [F+1:0]   diff;
    logic [F:0]     rem_next;
    logic [F-1:0]   quo_next;
    logic [F:0]     rem_reg;
    logic [F-1:0]   quo_reg;
    adm_side_t      side_reg;

    // shift the partial remainder and try to subtract the divisor
    always_comb
    begin
        shifted  = {rem_in, 1'b0};
        take     = shifted >= {1'b0, den};
        diff     = shifted - {1'b0, den};
        rem_next = take ? diff[F:0] : shifted[F:0];
        quo_next = {quo_in[F-2:0], take};
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;
    assign side_out = side_reg;
endmodule

// ----- sv/adm_lane.sv -----
// one axis: gain scaling and quadratic deadband as a pipeline
module adm_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic [SAMPLE_BITS+4:0]        en,
    input  logic signed [SAMPLE_BITS-1:0] raw,
    input  logic                          invert,
    input  logic [SAMPLE_BITS-2:0]        gain,
    input  logic [SAMPLE_BITS-2:0]        thr,
    input  logic [SAMPLE_BITS-2:0]        minv,
    input  logic [SAMPLE_BITS-1:0]        den,
    input  logic [SAMPLE_BITS-1:0]        omm,
    output logic signed [SAMPLE_BITS-1:0] db_out
);
    import adm_pkg::*;

    localparam int W  = SAMPLE_BITS;
    localparam int F  = SAMPLE_BITS - 1;
    localparam int DS = 3;          // first divider stage
    localparam int SQ = DS + F;     // squaring stage
    localparam int MU = SQ + 1;     // output span multiply stage
    localparam int AD = MU + 1;     // offset add and sign stage

    logic [W-1:0]      raw_u;
    logic [W-1:0]      mag0_next;
    logic [W-1:0]      mag0_reg;
    logic              neg0_reg;
    logic [W+F-1:0]    prod1;
    logic [F-1:0]      a1_reg;
    logic              neg1_reg;
    logic [F-1:0]      d2;
    logic [F:0]        rem2_reg;
    adm_side_t         side2_next;
    adm_side_t         side2_reg;
    logic [F:0]        rem_w  [0:F];
    logic [F-1:0]      quo_w  [0:F];
    adm_side_t         side_w [0:F];
    logic [2*F-1:0]    sq_prod;
    logic [F-1:0]      q_reg;
    adm_side_t         side_q_reg;
    logic [2*F:0]      span_prod;
    logic [F-1:0]      s_reg;
    adm_side_t         side_s_reg;
    logic [F:0]        mag_sum;
    logic [W-1:0]      mag_w;
    logic [W-1:0]      db_next;
    logic [W-1:0]      db_reg;

    // magnitude and sign of the raw sample
    assign raw_u     = raw;
    assign mag0_next = raw[W-1] ? (~raw_u + 1'b1) : raw_u;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mag0_reg <= mag0_next;
            neg0_reg <= raw[W-1] ^ invert;
        end
    end

    // gain scaling, truncated toward zero
    assign prod1 = (W+F)'(mag0_reg) * (W+F)'(gain);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            a1_reg   <= prod1[2*F-1:F];
            neg1_reg <= neg0_reg;
        end
    end

    // threshold compare and offset past threshold
    assign d2              = a1_reg - thr;
    assign side2_next.live = a1_reg > thr;
    assign side2_next.neg  = neg1_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            rem2_reg  <= {1'b0, d2};
            side2_reg <= side2_next;
        end
    end

    // restoring divider, one quotient bit per stage
    assign rem_w[0]  = rem2_reg;
    assign quo_w[0]  = '0;
    assign side_w[0] = side2_reg;

    for (genvar k = 0; k < F; k++)
    begin : g_div
        adm_div_step #(
            .FRAC_BITS (F)
        ) u_step (
            .clk      (clk),
            .en       (en[DS+k]),
            .den      (den),
            .rem_in   (rem_w[k]),
            .quo_in   (quo_w[k]),
            .side_in  (side_w[k]),
            .rem_out  (rem_w[k+1]),
            .quo_out  (quo_w[k+1]),
            .side_out (side_w[k+1])
        );
    end

    // square of the normalized offset
    assign sq_prod = (2*F)'(quo_w[F]) * (2*F)'(quo_w[F]);

    always_ff @(posedge clk)
    begin
        if (en[SQ])
        begin
            q_reg      <= sq_prod[2*F-1:F];
            side_q_reg <= side_w[F];
        end
    end

    // scale the parabola by the span above min_output
    assign span_prod = (2*F+1)'(omm) * (2*F+1)'(q_reg);

    always_ff @(posedge clk)
    begin
        if (en[MU])
        begin
            s_reg      <= span_prod[2*F-1:F];
            side_s_reg <= side_q_reg;
        end
    end

    // add the floor and apply the sign, zero inside the deadband
    assign mag_sum = {1'b0, minv} + {1'b0, s_reg};
    assign mag_w   = {1'b0, mag_sum[F-1:0]};

    always_comb
    begin
        if (!side_s_reg.live)
            db_next = '0;
        else if (side_s_reg.neg)
            db_next = ~mag_w + 1'b1;
        else
            db_next = mag_w;
    end

    always_ff @(posedge clk)
    begin
        if (en[AD])
            db_reg <= db_next;
    end

    assign db_out = db_reg;
endmodule

// ----- sv/adm_mix.sv -----
// arcade mixing of the shaped axes and output saturation
module adm_mix #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic [1:0]                    en,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic signed [SAMPLE_BITS-1:0] y,
    input  logic signed [SAMPLE_BITS-1:0] z,
    output logic signed [SAMPLE_BITS-1:0] left_cmd,
    output logic signed [SAMPLE_BITS-1:0] right_cmd
);
    import adm_pkg::*;

    localparam int W = SAMPLE_BITS;
    localparam int F = SAMPLE_BITS - 1;
    localparam logic signed [W+1:0] POS_LIM = {3'b000, {F{1'b1}}};
    localparam logic signed [W+1:0] NEG_LIM = {3'b111, {F{1'b0}}};

    logic signed [W:0]   xs;
    logic signed [W:0]   ys;
    logic signed [W:0]   zs;
    logic signed [W:0]   ax;
    logic signed [W:0]   ay;
    logic signed [W:0]   diff;
    logic signed [W:0]   inner;
    logic signed [W:0]   l_next;
    logic signed [W:0]   r_next;
    logic signed [W:0]   l_reg;
    logic signed [W:0]   r_reg;
    logic signed [W+1:0] r_sat;
    logic signed [W+1:0] r_neg;
    logic signed [W-1:0] left_reg;
    logic signed [W-1:0] right_reg;

    // clamp to the representable range
    function automatic logic signed [W+1:0] sat_w(input logic signed [W+1:0] v);
        logic signed [W+1:0] res;
        if (v < NEG_LIM)
            res = NEG_LIM;
        else if (v > POS_LIM)
            res = POS_LIM;
        else
            res = v;
        return res;
    endfunction

    // side selection: twist wins, else x slows the inner side
    always_comb
    begin
        xs    = (W+1)'(x);
        ys    = (W+1)'(y);
        zs    = (W+1)'(z);
        ax    = (xs < 0) ? -xs : xs;
        ay    = (ys < 0) ? -ys : ys;
        diff  = ay - ax;
        if (ys > 0)
            inner = diff;
        else if (ys < 0)
            inner = -diff;
        else
            inner = '0;
        if (zs != 0)
        begin
            l_next = zs;
            r_next = -zs;
        end
        else if (xs > 0)
        begin
            l_next = ys;
            r_next = inner;
        end
        else if (xs < 0)
        begin
            l_next = inner;
            r_next = ys;
        end
        else
        begin
            l_next = ys;
            r_next = ys;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            l_reg <= l_next;
            r_reg <= r_next;
        end
    end

    // saturate both sides and negate the right one
    assign r_sat = sat_w((W+2)'(r_reg));
    assign r_neg = -r_sat;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            left_reg  <= W'(sat_w((W+2)'(l_reg)));
            right_reg <= W'(sat_w(r_neg));
        end
    end

    assign left_cmd  = left_reg;
    assign right_cmd = right_reg;
endmodule
